/* hw/rtl/mrfl_pkg.sv */
// shared types and constants for the two-class mrf pixel labeler
package mrfl_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int COL_W     = $clog2(MAX_WIDTH);
    localparam int MIN_DIM   = 3;
    localparam int MAX_HEIGHT = 4095;

    localparam logic [7:0] LABEL_ONE = 8'd100;
    localparam logic [7:0] LABEL_TWO = 8'd200;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH    = 3'd0,
        REG_IMAGE_HEIGHT   = 3'd1,
        REG_MEAN_ONE       = 3'd2,
        REG_MEAN_TWO       = 3'd3,
        REG_CLASS_SPLIT    = 3'd4,
        REG_SMOOTH_WEIGHT  = 3'd5,
        REG_VARIANCE_SCALE = 3'd6
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIN,
        ST_COST,
        ST_HOLD
    } t_state;

    typedef struct packed {
        logic [15:0] raw_pixel;
        logic [15:0] prior_value;
        logic        frame_start;
    } t_in_word;

    typedef struct packed {
        logic [7:0]  pixel_label;
        logic [9:0]  label_column;
        logic [11:0] label_row;
        logic        frame_done;
    } t_out_word;

    typedef struct packed {
        logic [10:0] image_width;
        logic [11:0] image_height;
        logic [15:0] mean_one;
        logic [15:0] mean_two;
        logic [15:0] class_split;
        logic [23:0] smooth_weight;
        logic [15:0] variance_scale;
    } t_cfg;

    typedef struct packed {
        logic [15:0] raw_top;
        logic [15:0] raw_bot;
        logic [15:0] pri_top;
        logic [15:0] pri_bot;
    } t_line_entry;

    typedef logic [8:0][15:0] t_win;

endpackage

/* hw/rtl/mrfl_line_mem.sv */
// two-line store for raw and prior values, one entry per column, cleared after reset
module mrfl_line_mem (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_rd_en,
    input  logic [mrfl_pkg::COL_W-1:0] i_rd_addr,
    output mrfl_pkg::t_line_entry      o_rd_data,
    input  logic                       i_wr_en,
    input  logic [mrfl_pkg::COL_W-1:0] i_wr_addr,
    input  mrfl_pkg::t_line_entry      i_wr_data,
    output logic                       o_busy
);

    mrfl_pkg::t_line_entry r_mem [mrfl_pkg::MAX_WIDTH];
    mrfl_pkg::t_line_entry r_rd_data;
    logic [mrfl_pkg::COL_W-1:0] r_clr_addr;
    logic                       r_busy;

    // clearing sweep
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == mrfl_pkg::COL_W'(mrfl_pkg::MAX_WIDTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_busy;

endmodule

/* hw/rtl/mrfl_cost.sv */
// four-stage energy pipeline comparing the two class costs of one window
module mrfl_cost (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  mrfl_pkg::t_win  i_raw_win,
    input  mrfl_pkg::t_win  i_pri_win,
    input  mrfl_pkg::t_cfg  i_cfg,
    output logic            o_done,
    output logic            o_first_class
);

    logic r_v1, r_v2, r_v3, r_v4;

    logic signed [19:0] r_d1, r_d2;
    logic [3:0]         r_na, r_nb;
    logic [37:0]        r_dd1, r_dd2;
    logic signed [30:0] r_ds2, r_ds3;
    logic [53:0]        r_p1, r_p2;
    logic               r_first;

    logic [18:0]        c5;
    logic [17:0]        cross_sum;
    logic signed [19:0] d1, d2;
    logic [7:0]         lt, gt;
    logic [3:0]         na, nb;
    logic signed [39:0] sq1, sq2;
    logic signed [24:0] w_s;
    logic signed [5:0]  f;
    logic signed [30:0] ds;
    logic [53:0]        p1, p2;
    logic signed [54:0] pd;

    // stage one: residuals and neighbour counts
    always_comb begin
        c5        = {1'b0, i_raw_win[4], 2'b00} + 19'(i_raw_win[4]);
        cross_sum = 18'(i_raw_win[1]) + 18'(i_raw_win[3]) + 18'(i_raw_win[5])
                  + 18'(i_raw_win[7]);
        d1 = $signed({1'b0, c5}) - $signed({2'b00, cross_sum})
           - $signed({4'b0000, i_cfg.mean_one});
        d2 = $signed({1'b0, c5}) - $signed({2'b00, cross_sum})
           - $signed({4'b0000, i_cfg.mean_two});
        for (int k = 0; k < 4; k++) begin
            lt[k]     = i_pri_win[k] < i_cfg.class_split;
            gt[k]     = i_pri_win[k] > i_cfg.class_split;
            lt[k + 4] = i_pri_win[k + 5] < i_cfg.class_split;
            gt[k + 4] = i_pri_win[k + 5] > i_cfg.class_split;
        end
        na = 4'($countones(lt));
        nb = 4'($countones(gt));
    end

    // stage two: squares and smoothness difference
    always_comb begin
        sq1 = r_d1 * r_d1;
        sq2 = r_d2 * r_d2;
        w_s = $signed({1'b0, i_cfg.smooth_weight});
        f   = $signed({1'b0, r_na, 1'b0}) - $signed({1'b0, r_nb, 1'b0});
        ds  = w_s * f;
    end

    // stage three: variance scaling
    always_comb begin
        p1 = 54'(r_dd1) * 54'(i_cfg.variance_scale);
        p2 = 54'(r_dd2) * 54'(i_cfg.variance_scale);
    end

    // stage four: e1 < e2 as p1 - p2 < s2 - s1
    assign pd = $signed({1'b0, r_p1}) - $signed({1'b0, r_p2});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_start;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_d1 <= d1;
            r_d2 <= d2;
            r_na <= na;
            r_nb <= nb;
        end
        if (r_v1) begin
            r_dd1 <= sq1[37:0];
            r_dd2 <= sq2[37:0];
            r_ds2 <= ds;
        end
        if (r_v2) begin
            r_p1  <= p1;
            r_p2  <= p2;
            r_ds3 <= r_ds2;
        end
        if (r_v3) begin
            r_first <= pd < 55'(r_ds3);
        end
    end

    assign o_done        = r_v4;
    assign o_first_class = r_first;

endmodule

/* hw/rtl/two_class_mrf_pixel_labeler_unit.sv */
// top level of the two-class mrf pixel labeler: position tracking, windows, control
// path: an accepted word goes through the line memory read, the window update, the cost
//   start register and the four-stage cost pipeline into the output register; edge pixels
//   skip the cost pipeline; a new input word is taken only once the last one is through
// reset (synchronous, active low): clearing sweep of the line memory,
//   no input words taken meanwhile; configuration writes are taken throughout
module two_class_mrf_pixel_labeler_unit (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  mrfl_pkg::t_in_word  i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output mrfl_pkg::t_out_word o_out_word,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [2:0]          i_cfg_index,
    input  logic [23:0]         i_cfg_data
);

    mrfl_pkg::t_state r_state, n_state;
    mrfl_pkg::t_cfg   r_cfg;

    logic [mrfl_pkg::COL_W-1:0] r_col, n_col;
    logic [11:0]                r_row, n_row;
    logic [mrfl_pkg::COL_W-1:0] r_x;
    logic [15:0]                r_pix, r_pri;
    logic                       r_produce;
    logic [9:0]                 r_lab_col;
    logic [11:0]                r_lab_row;
    logic                       r_lab_done;
    logic                       r_start;
    mrfl_pkg::t_win             r_raw_win, r_pri_win;
    logic                       r_out_valid;
    mrfl_pkg::t_out_word        r_out_word;

    logic                       accept;
    logic                       mem_busy;
    mrfl_pkg::t_line_entry      rd_data, wr_data;
    logic                       mem_wr;
    logic                       out_load;
    logic                       cost_done, cost_first;
    logic [mrfl_pkg::COL_W-1:0] x;
    logic [11:0]                y;
    logic [10:0]                w_eff;
    logic [11:0]                h_eff;
    logic                       produce;
    logic                       last_col;
    logic                       last_row;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.image_width    <= 11'd256;
            r_cfg.image_height   <= 12'd256;
            r_cfg.mean_one       <= 16'd100;
            r_cfg.mean_two       <= 16'd200;
            r_cfg.class_split    <= 16'd150;
            r_cfg.smooth_weight  <= 24'd65536;
            r_cfg.variance_scale <= 16'd1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                mrfl_pkg::REG_IMAGE_WIDTH:    r_cfg.image_width    <= i_cfg_data[10:0];
                mrfl_pkg::REG_IMAGE_HEIGHT:   r_cfg.image_height   <= i_cfg_data[11:0];
                mrfl_pkg::REG_MEAN_ONE:       r_cfg.mean_one       <= i_cfg_data[15:0];
                mrfl_pkg::REG_MEAN_TWO:       r_cfg.mean_two       <= i_cfg_data[15:0];
                mrfl_pkg::REG_CLASS_SPLIT:    r_cfg.class_split    <= i_cfg_data[15:0];
                mrfl_pkg::REG_SMOOTH_WEIGHT:  r_cfg.smooth_weight  <= i_cfg_data;
                mrfl_pkg::REG_VARIANCE_SCALE: r_cfg.variance_scale <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // raster position
    always_comb begin
        if (r_cfg.image_width < 11'(mrfl_pkg::MIN_DIM)) begin
            w_eff = 11'(mrfl_pkg::MIN_DIM);
        end else if (r_cfg.image_width > 11'(mrfl_pkg::MAX_WIDTH)) begin
            w_eff = 11'(mrfl_pkg::MAX_WIDTH);
        end else begin
            w_eff = r_cfg.image_width;
        end
        if (r_cfg.image_height < 12'(mrfl_pkg::MIN_DIM)) begin
            h_eff = 12'(mrfl_pkg::MIN_DIM);
        end else begin
            h_eff = r_cfg.image_height;
        end
        x = i_in_word.frame_start ? '0 : r_col;
        y = i_in_word.frame_start ? '0 : r_row;
        produce  = (x >= mrfl_pkg::COL_W'(2)) && (y >= 12'd2);
        last_col = ({1'b0, x} + 11'd1) >= w_eff;
        last_row = ({1'b0, y} + 13'd1) >= {1'b0, h_eff};
        if (last_col) begin
            n_col = '0;
            n_row = last_row ? '0 : y + 12'd1;
        end else begin
            n_col = x + 1'b1;
            n_row = y;
        end
    end

    assign accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_x        <= x;
            r_pix      <= i_in_word.raw_pixel;
            r_pri      <= i_in_word.prior_value;
            r_lab_col  <= 10'(x - 1'b1);
            r_lab_row  <= y - 12'd1;
            r_lab_done <= ({1'b0, x} == w_eff - 11'd1) && (y == h_eff - 12'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_produce <= 1'b0;
        end else if (accept) begin
            r_produce <= produce;
        end
    end

    // line memory
    assign wr_data = '{raw_top: rd_data.raw_bot, raw_bot: r_pix,
                       pri_top: rd_data.pri_bot, pri_bot: r_pri};

    mrfl_line_mem u_line_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (x),
        .o_rd_data (rd_data),
        .i_wr_en   (mem_wr),
        .i_wr_addr (r_x),
        .i_wr_data (wr_data),
        .o_busy    (mem_busy)
    );

    // 3x3 windows
    always_ff @(posedge i_clk) begin
        if (mem_wr) begin
            for (int r = 0; r < 3; r++) begin
                r_raw_win[r * 3]     <= r_raw_win[r * 3 + 1];
                r_raw_win[r * 3 + 1] <= r_raw_win[r * 3 + 2];
                r_pri_win[r * 3]     <= r_pri_win[r * 3 + 1];
                r_pri_win[r * 3 + 1] <= r_pri_win[r * 3 + 2];
            end
            r_raw_win[2] <= rd_data.raw_top;
            r_raw_win[5] <= rd_data.raw_bot;
            r_raw_win[8] <= r_pix;
            r_pri_win[2] <= rd_data.pri_top;
            r_pri_win[5] <= rd_data.pri_bot;
            r_pri_win[8] <= r_pri;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= 1'b0;
        end else begin
            r_start <= mem_wr && r_produce;
        end
    end

    mrfl_cost u_cost (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (r_start),
        .i_raw_win     (r_raw_win),
        .i_pri_win     (r_pri_win),
        .i_cfg         (r_cfg),
        .o_done        (cost_done),
        .o_first_class (cost_first)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= mrfl_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            mrfl_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = mrfl_pkg::ST_WIN;
                end
            end
            mrfl_pkg::ST_WIN: begin
                n_state = r_produce ? mrfl_pkg::ST_COST : mrfl_pkg::ST_IDLE;
            end
            mrfl_pkg::ST_COST: begin
                if (cost_done) begin
                    n_state = (!r_out_valid || i_out_ready) ? mrfl_pkg::ST_IDLE
                                                            : mrfl_pkg::ST_HOLD;
                end
            end
            mrfl_pkg::ST_HOLD: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = mrfl_pkg::ST_IDLE;
                end
            end
            default: n_state = mrfl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = 1'b0;
        mem_wr     = 1'b0;
        out_load   = 1'b0;
        case (r_state)
            mrfl_pkg::ST_IDLE: o_in_ready = !mem_busy;
            mrfl_pkg::ST_WIN:  mem_wr     = 1'b1;
            mrfl_pkg::ST_COST: out_load   = cost_done && (!r_out_valid || i_out_ready);
            mrfl_pkg::ST_HOLD: out_load   = !r_out_valid || i_out_ready;
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_word.pixel_label  <= cost_first ? mrfl_pkg::LABEL_ONE
                                                  : mrfl_pkg::LABEL_TWO;
            r_out_word.label_column <= r_lab_col;
            r_out_word.label_row    <= r_lab_row;
            r_out_word.frame_done   <= r_lab_done;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

`ifndef SYNTH
    a_ready_not_clearing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !mem_busy)
        else $error("input word taken during line memory clear");

    a_accept_to_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == mrfl_pkg::ST_WIN))
        else $error("accepted word did not move to window update");

    a_done_in_cost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cost_done |-> (r_state == mrfl_pkg::ST_COST))
        else $error("cost result outside cost state");

    a_start_after_window: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_start |-> $past(r_state == mrfl_pkg::ST_WIN))
        else $error("cost start without window update");
`endif

endmodule

/* dv/tb_two_class_mrf_pixel_labeler_unit.sv */
`timescale 1ns / 1ps
// testbench for the two-class mrf pixel labeler unit: raster frames against a label predictor
module tb_two_class_mrf_pixel_labeler_unit;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 5;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int CYCLE_LIMIT   = 1000000;
    localparam int RANDOM_ITEMS  = 400;
    localparam int REPORT_LIMIT  = 10;
    localparam int WIDE_ITEMS    = 40;

    class label_scoreboard;
        mrfl_pkg::t_cfg      regs;
        logic [15:0]         raw_lines [2*mrfl_pkg::MAX_WIDTH];
        logic [15:0]         prior_lines [2*mrfl_pkg::MAX_WIDTH];
        logic [15:0]         raw_win [9];
        logic [15:0]         prior_win [9];
        int                  column;
        int                  row;
        mrfl_pkg::t_out_word labels_due [$];
        int                  errors;

        function new();
            regs.image_width    = 11'd256;
            regs.image_height   = 12'd256;
            regs.mean_one       = 16'd100;
            regs.mean_two       = 16'd200;
            regs.class_split    = 16'd150;
            regs.smooth_weight  = 24'd65536;
            regs.variance_scale = 16'd1;
            foreach (raw_lines[i]) begin
                raw_lines[i]   = '0;
                prior_lines[i] = '0;
            end
            foreach (raw_win[i]) begin
                raw_win[i]   = '0;
                prior_win[i] = '0;
            end
            column = 0;
            row    = 0;
            errors = 0;
        endfunction

        function void set_reg(mrfl_pkg::t_reg_idx idx, logic [23:0] data);
            case (idx)
                mrfl_pkg::REG_IMAGE_WIDTH:    regs.image_width    = data[10:0];
                mrfl_pkg::REG_IMAGE_HEIGHT:   regs.image_height   = data[11:0];
                mrfl_pkg::REG_MEAN_ONE:       regs.mean_one       = data[15:0];
                mrfl_pkg::REG_MEAN_TWO:       regs.mean_two       = data[15:0];
                mrfl_pkg::REG_CLASS_SPLIT:    regs.class_split    = data[15:0];
                mrfl_pkg::REG_SMOOTH_WEIGHT:  regs.smooth_weight  = data;
                mrfl_pkg::REG_VARIANCE_SCALE: regs.variance_scale = data[15:0];
                default: ;
            endcase
        endfunction

        function longint class_cost(longint mean, bit second);
            longint centre, cross_sum, resid, cost, weight;
            bit     agree;
            int     k;
            centre    = longint'(raw_win[4]);
            cross_sum = longint'(raw_win[1]) + longint'(raw_win[3])
                      + longint'(raw_win[5]) + longint'(raw_win[7]);
            resid  = 5 * centre - cross_sum - mean;
            cost   = resid * resid * longint'(regs.variance_scale);
            weight = longint'(regs.smooth_weight);
            for (k = 0; k < 9; k++) begin
                if (k != 4) begin
                    agree = second ? (prior_win[k] > regs.class_split)
                                   : (prior_win[k] < regs.class_split);
                    cost += agree ? -weight : weight;
                end
            end
            return cost;
        endfunction

        function void take_pixel(mrfl_pkg::t_in_word word);
            int                  w, h, x, y, r;
            mrfl_pkg::t_out_word due;
            w = regs.image_width;
            h = regs.image_height;
            if (w < mrfl_pkg::MIN_DIM) w = mrfl_pkg::MIN_DIM;
            if (w > mrfl_pkg::MAX_WIDTH) w = mrfl_pkg::MAX_WIDTH;
            if (h < mrfl_pkg::MIN_DIM) h = mrfl_pkg::MIN_DIM;
            if (h > mrfl_pkg::MAX_HEIGHT) h = mrfl_pkg::MAX_HEIGHT;
            if (word.frame_start) begin
                column = 0;
                row    = 0;
            end
            x = column;
            y = row;
            if (x >= mrfl_pkg::MAX_WIDTH) x = mrfl_pkg::MAX_WIDTH - 1;
            for (r = 0; r < 3; r++) begin
                raw_win[r*3]     = raw_win[r*3 + 1];
                raw_win[r*3 + 1] = raw_win[r*3 + 2];
                prior_win[r*3]     = prior_win[r*3 + 1];
                prior_win[r*3 + 1] = prior_win[r*3 + 2];
            end
            raw_win[2]   = raw_lines[x];
            raw_win[5]   = raw_lines[mrfl_pkg::MAX_WIDTH + x];
            raw_win[8]   = word.raw_pixel;
            prior_win[2] = prior_lines[x];
            prior_win[5] = prior_lines[mrfl_pkg::MAX_WIDTH + x];
            prior_win[8] = word.prior_value;
            raw_lines[x]                        = raw_lines[mrfl_pkg::MAX_WIDTH + x];
            raw_lines[mrfl_pkg::MAX_WIDTH + x]  = word.raw_pixel;
            prior_lines[x]                      = prior_lines[mrfl_pkg::MAX_WIDTH + x];
            prior_lines[mrfl_pkg::MAX_WIDTH + x] = word.prior_value;
            if (x >= 2 && y >= 2) begin
                due.pixel_label  = (class_cost(regs.mean_one, 1'b0)
                                    < class_cost(regs.mean_two, 1'b1))
                                 ? mrfl_pkg::LABEL_ONE : mrfl_pkg::LABEL_TWO;
                due.label_column = 10'(x - 1);
                due.label_row    = 12'(y - 1);
                due.frame_done   = (x == w - 1 && y == h - 1);
                labels_due.push_back(due);
            end
            if (x + 1 >= w) begin
                column = 0;
                row    = (y + 1 >= h) ? 0 : y + 1;
            end else begin
                column = x + 1;
            end
        endfunction

        function void report(string what, mrfl_pkg::t_out_word want,
                             mrfl_pkg::t_out_word got);
            if (errors < REPORT_LIMIT)
                $display({"%s: expected label %0d col %0d row %0d done %0b, ",
                          "got label %0d col %0d row %0d done %0b"},
                         what, want.pixel_label, want.label_column, want.label_row,
                         want.frame_done, got.pixel_label, got.label_column, got.label_row,
                         got.frame_done);
            errors++;
        endfunction

        function void check_label(mrfl_pkg::t_out_word got);
            mrfl_pkg::t_out_word want;
            if (labels_due.size() == 0) begin
                report("unexpected word", '0, got);
                return;
            end
            want = labels_due.pop_front();
            if (got.pixel_label !== want.pixel_label || got.label_column !== want.label_column
                || got.label_row !== want.label_row || got.frame_done !== want.frame_done)
                report("label mismatch", want, got);
        endfunction

        function int pending();
            return labels_due.size();
        endfunction
    endclass

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    mrfl_pkg::t_in_word  i_in_word;
    logic                o_out_valid;
    logic                i_out_ready = 1'b0;
    mrfl_pkg::t_out_word o_out_word;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [2:0]          i_cfg_index;
    logic [23:0]         i_cfg_data;

    label_scoreboard sb;
    int send_idle_pct  = 13;
    int recv_idle_pct  = 47;
    int hold_requests  = 0;
    int hold_served    = 0;
    int hold_left      = 0;
    int cycles         = 0;

    two_class_mrf_pixel_labeler_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (hold_requests != hold_served) begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_label(o_out_word);
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic write_reg(mrfl_pkg::t_reg_idx idx, logic [23:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
    endtask

    task automatic program_regs(mrfl_pkg::t_cfg c);
        write_reg(mrfl_pkg::REG_IMAGE_WIDTH, 24'(c.image_width));
        write_reg(mrfl_pkg::REG_IMAGE_HEIGHT, 24'(c.image_height));
        write_reg(mrfl_pkg::REG_MEAN_ONE, 24'(c.mean_one));
        write_reg(mrfl_pkg::REG_MEAN_TWO, 24'(c.mean_two));
        write_reg(mrfl_pkg::REG_CLASS_SPLIT, 24'(c.class_split));
        write_reg(mrfl_pkg::REG_SMOOTH_WEIGHT, c.smooth_weight);
        write_reg(mrfl_pkg::REG_VARIANCE_SCALE, 24'(c.variance_scale));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic put_word(mrfl_pkg::t_in_word word);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_word  <= word;
        do @(posedge i_clk); while (!o_in_ready);
        sb.take_pixel(word);
    endtask

    // lets the last labels out and any edge words drain before a register write
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    function automatic logic [23:0] pick_value(int bits);
        logic [23:0] top;
        top = 24'((64'd1 << bits) - 1);
        case ($urandom_range(5))
            0: return '0;
            1: return top;
            default: return 24'($urandom) & top;
        endcase
    endfunction

    function automatic mrfl_pkg::t_cfg random_cfg(int width, int height);
        mrfl_pkg::t_cfg c;
        c.image_width    = 11'(width);
        c.image_height   = 12'(height);
        c.mean_one       = 16'(pick_value(16));
        c.mean_two       = 16'(pick_value(16));
        c.class_split    = 16'(pick_value(16));
        c.smooth_weight  = pick_value(24);
        c.variance_scale = 16'(pick_value(16));
        return c;
    endfunction

    function automatic int clamp_dim(int value, int top);
        if (value < mrfl_pkg::MIN_DIM) return mrfl_pkg::MIN_DIM;
        if (value > top) return top;
        return value;
    endfunction

    function automatic mrfl_pkg::t_in_word make_word(mrfl_pkg::t_cfg c, bit structured,
                                                     bit start);
        mrfl_pkg::t_in_word word;
        int                 level;
        if (structured) begin
            level = $urandom_range(1) ? int'(c.mean_one) : int'(c.mean_two);
            level = level + int'($urandom_range(48)) - 24;
            if (level < 0) level = 0;
            if (level > 65535) level = 65535;
            word.raw_pixel = 16'(level);
            case ($urandom_range(2))
                0: word.prior_value = word.raw_pixel;
                1: word.prior_value = 16'(mrfl_pkg::LABEL_ONE);
                default: word.prior_value = 16'(mrfl_pkg::LABEL_TWO);
            endcase
            word.frame_start = start;
        end else begin
            word.raw_pixel   = 16'($urandom);
            word.prior_value = 16'($urandom);
            word.frame_start = start | ($urandom_range(19) == 0);
        end
        return word;
    endfunction

    task automatic run_phase(mrfl_pkg::t_cfg c, int count, bit structured, bit fresh);
        program_regs(c);
        for (int i = 0; i < count; i++)
            put_word(make_word(c, structured, fresh && i == 0));
        settle();
    endtask

    initial begin
        mrfl_pkg::t_cfg     c;
        mrfl_pkg::t_in_word word;
        int                 ph, random_items, weff, heff, count;
        bit                 structured, fresh;
        sb = new();
        i_rst_n     <= 1'b0;
        i_in_valid  <= 1'b0;
        i_in_word   <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // flat image, equal means, every prior on the split: tie gives the second class
        c = '0;
        c.image_width    = 11'd3;
        c.image_height   = 12'd3;
        c.class_split    = 16'd150;
        c.smooth_weight  = 24'd65536;
        c.variance_scale = 16'd1;
        program_regs(c);
        for (int i = 0; i < 9; i++) begin
            word.raw_pixel   = '0;
            word.prior_value = 16'd150;
            word.frame_start = (i == 0);
            put_word(word);
        end
        settle();

        // clamped geometry, extreme values, wrap into a new frame, restart mid frame
        c.image_width    = 11'd0;
        c.image_height   = 12'd2;
        c.mean_one       = 16'd0;
        c.mean_two       = 16'hFFFF;
        c.class_split    = 16'hFFFF;
        c.smooth_weight  = 24'hFFFFFF;
        c.variance_scale = 16'hFFFF;
        program_regs(c);
        for (int i = 0; i < 11; i++) begin
            word.raw_pixel   = i[0] ? 16'hFFFF : 16'h0000;
            word.prior_value = i[1] ? 16'hFFFF : 16'h0000;
            word.frame_start = (i == 2);
            put_word(word);
        end
        settle();

        random_items = 0;
        for (ph = 0; ph < 8 || random_items < RANDOM_ITEMS; ph++) begin
            if (random_items < RANDOM_ITEMS / 3) begin
                send_idle_pct = 13;
                recv_idle_pct = 47;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                send_idle_pct = 47;
                recv_idle_pct = 13;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            if (ph == 3) begin
                c = random_cfg(2047, 3);
                run_phase(c, WIDE_ITEMS, 1'b1, 1'b1);
                random_items += WIDE_ITEMS;
            end else if (ph == 6) begin
                c = random_cfg(3, mrfl_pkg::MAX_HEIGHT);
                run_phase(c, 18, 1'b1, 1'b1);
                random_items += 18;
            end else begin
                c = random_cfg($urandom_range(12), $urandom_range(8));
                structured = ($urandom_range(3) != 0);
                fresh      = ($urandom_range(3) != 0);
                if (ph == 1) begin
                    c.image_width  = 11'd8;
                    c.image_height = 12'd6;
                    structured     = 1'b1;
                    fresh          = 1'b1;
                    hold_requests++;
                end
                weff  = clamp_dim(c.image_width, mrfl_pkg::MAX_WIDTH);
                heff  = clamp_dim(c.image_height, mrfl_pkg::MAX_HEIGHT);
                count = weff * heff + $urandom_range(weff - 1);
                run_phase(c, count, structured, fresh);
                random_items += count;
            end
        end

        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
